/* hw/rtl/area_average_rgb_downscaler_defines.svh */
// assertion macros used by the checker file
`ifndef AREA_AVERAGE_RGB_DOWNSCALER_DEFINES_SVH
`define AREA_AVERAGE_RGB_DOWNSCALER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AARD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define AARD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/aard_pkg.sv */
package aard_pkg;

	localparam int CFG_W = 13;
	localparam int PIX_W = 8;
	localparam int POS_W = 12;
	localparam int CFG_IDX_W = 2;
	localparam int QUO_W = 9;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SRC_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_SRC_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_DST_WIDTH  = 2'd2;
	localparam cfg_idx_t CFG_DST_HEIGHT = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_WB,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

/* hw/rtl/aard_pix_if.sv */
interface aard_pix_if;
	import aard_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

/* hw/rtl/aard_res_if.sv */
interface aard_res_if;
	import aard_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic [POS_W-1:0] out_col;
	logic [POS_W-1:0] out_row;
	logic             frame_last;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output out_col, output out_row, output frame_last, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input out_col, input out_row, input frame_last, output ready);
endinterface

/* hw/rtl/aard_round_div.sv */
module aard_round_div #(
	parameter int CHANNELS = 3,
	parameter int ACC_W = 32,
	parameter int D_W = 26
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ACC_W-1:0]                 sum [CHANNELS],
	input  logic [D_W-1:0]                   d,
	output logic                             done,
	output logic [aard_pkg::PIX_W-1:0]       quo [CHANNELS]
);
	import aard_pkg::*;

	localparam int R_W = D_W + 10;

	logic [R_W-1:0]   rem_q [CHANNELS];
	logic [QUO_W-1:0] qb_q [CHANNELS];
	logic [R_W-1:0]   dsr_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	// restoring division of 2s+d by 2d, one quotient bit per cycle, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= R_W'(d) << QUO_W;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				rem_q[ch] <= (R_W'(sum[ch]) << 1) + R_W'(d);
				qb_q[ch]  <= '0;
			end
		end else if (busy_q) begin
			dsr_q <= dsr_q >> 1;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (rem_q[ch] >= dsr_q) begin
					rem_q[ch] <= rem_q[ch] - dsr_q;
					qb_q[ch]  <= {qb_q[ch][QUO_W-2:0], 1'b1};
				end else begin
					qb_q[ch] <= {qb_q[ch][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	// saturate to the pixel range
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			quo[ch] = qb_q[ch][QUO_W-1] ? {PIX_W{1'b1}} : qb_q[ch][PIX_W-1:0];
		end
	end

	assign done = done_q;
endmodule

/* hw/rtl/area_average_rgb_downscaler.sv */
// Area-average RGB downscaler. Source pixels come in raster order on pix, one item
// each; averaged output pixels leave on res with their column, row and a
// frame-last flag, each one as soon as its last contributing source pixel has been
// taken. Sizes are set through the write port (0 source width, 1 source height,
// 2 destination width, 3 destination height); out-of-range values are clamped and
// every write restarts the frame. Channel sums for two output rows live in two
// single-port-style RAMs split by output column parity, so the two columns a
// source pixel can touch are read and written back together. One item at a time
// goes through read, two multiply stages and write-back; an item that completes
// an output pixel then goes through the bit-serial divider and an emit state, and
// waits there while the previous result is still not taken. After reset and after
// every register write the RAMs are swept to zero, one entry per cycle, all
// ceil(MAX_DST_WIDTH/2) entries (2048 at the defaults), with pix.ready low.
module area_average_rgb_downscaler #(
	parameter int MAX_DST_WIDTH = 4096,
	parameter int MAX_SRC_DIM = 4096,
	parameter int CHANNELS = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	aard_pix_if.sink                      pix,
	aard_res_if.source                    res,
	input  logic                          wr_en,
	input  aard_pkg::cfg_idx_t            wr_index,
	input  logic [aard_pkg::CFG_W-1:0]    wr_data
);
	import aard_pkg::*;

	// sizes and derived widths
	localparam int DIM_W = $clog2(MAX_SRC_DIM + 1);
	localparam int LOG_W = $clog2(MAX_SRC_DIM);
	localparam int ACC_W = 2 * LOG_W + 8;       // max sum is 255 * sw * sh
	localparam int WP_W  = 2 * DIM_W;
	localparam int COL_W = $clog2(MAX_DST_WIDTH);
	localparam int HALF  = (MAX_DST_WIDTH + 1) / 2;
	localparam int AW    = $clog2(HALF);
	localparam int ENT_W = 2 * CHANNELS * ACC_W;  // both row banks of one column

	// configuration, raw and clamped
	logic [CFG_W-1:0] src_w_raw_q, src_h_raw_q, dst_w_raw_q, dst_h_raw_q;
	logic [DIM_W-1:0] sw_q, sh_q, dw_q, dh_q;
	logic [DIM_W-1:0] sw_c, sh_c, dw_c, dh_c, dw_hi;
	logic [WP_W-1:0]  d_q;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		if (v == '0) begin
			return DIM_W'(1);
		end else if (32'(v) > 32'(hi)) begin
			return hi;
		end else begin
			return DIM_W'(v);
		end
	endfunction

	always_comb begin
		sw_c  = clamp_dim(src_w_raw_q, DIM_W'(MAX_SRC_DIM));
		sh_c  = clamp_dim(src_h_raw_q, DIM_W'(MAX_SRC_DIM));
		dw_hi = (32'(sw_c) < 32'(MAX_DST_WIDTH)) ? sw_c : DIM_W'(MAX_DST_WIDTH);
		dw_c  = clamp_dim(dst_w_raw_q, dw_hi);
		dh_c  = clamp_dim(dst_h_raw_q, sh_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_raw_q <= CFG_W'(1);
			src_h_raw_q <= CFG_W'(1);
			dst_w_raw_q <= CFG_W'(1);
			dst_h_raw_q <= CFG_W'(1);
			sw_q        <= DIM_W'(1);
			sh_q        <= DIM_W'(1);
			dw_q        <= DIM_W'(1);
			dh_q        <= DIM_W'(1);
			d_q         <= WP_W'(1);
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CFG_SRC_WIDTH:  src_w_raw_q <= wr_data;
					CFG_SRC_HEIGHT: src_h_raw_q <= wr_data;
					CFG_DST_WIDTH:  dst_w_raw_q <= wr_data;
					CFG_DST_HEIGHT: dst_h_raw_q <= wr_data;
				endcase
			end
			// clamped sizes settle during the clearing sweep that follows a write
			sw_q <= sw_c;
			sh_q <= sh_c;
			dw_q <= dw_c;
			dh_q <= dh_c;
			d_q  <= sw_q * sh_q;
		end
	end

	// sequencer
	state_t state_q, state_n;
	logic [AW-1:0] clr_q;
	logic clr_last;

	logic accept, rd_en, clr_we, wb_we, div_start, load_out, out_free;
	logic div_done, emit_q;

	assign accept   = pix.valid & pix.ready;
	assign out_free = !res.valid || res.ready;
	assign clr_last = clr_q == AW'(HALF - 1);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_n = ST_IDLE;
			ST_IDLE:  if (pix.valid) state_n = ST_MUL1;
			ST_MUL1:  state_n = ST_MUL2;
			ST_MUL2:  state_n = ST_WB;
			ST_WB:    state_n = emit_q ? ST_DIV : ST_IDLE;
			ST_DIV:   if (div_done) state_n = ST_EMIT;
			ST_EMIT:  if (out_free) state_n = ST_IDLE;
		endcase
		// a register write restarts the frame from a fresh sweep
		if (wr_en) state_n = ST_CLEAR;
	end

	always_comb begin
		pix.ready = 1'b0;
		rd_en     = 1'b0;
		clr_we    = 1'b0;
		wb_we     = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_CLEAR: clr_we = 1'b1;
			ST_IDLE: begin
				pix.ready = 1'b1;
				rd_en     = 1'b1;
			end
			ST_MUL1, ST_MUL2, ST_DIV: ;
			ST_WB: begin
				wb_we     = 1'b1;
				div_start = emit_q;
			end
			ST_EMIT: load_out = out_free;
		endcase
	end

	// raster position and phase counters, advanced at each accepted item
	logic [DIM_W-1:0] scol_q, srow_q, hph_q, vph_q, drow_q;
	logic [COL_W-1:0] dcol_q;
	logic [DIM_W:0]   hnew, vnew;
	logic             col_done, row_done;
	logic [DIM_W-1:0] wh_cu, wh_nx, wv_cu, wv_nx;
	logic [DIM_W-1:0] scol_n, srow_n, hph_n, vph_n, drow_n;
	logic [COL_W-1:0] dcol_n;
	logic             last_c, cn_ok_c, par_c;
	logic [AW-1:0]    half_c, adr_e_c, adr_o_c;

	always_comb begin
		hnew     = {1'b0, hph_q} + {1'b0, dw_q};
		vnew     = {1'b0, vph_q} + {1'b0, dh_q};
		col_done = hnew >= {1'b0, sw_q};
		row_done = vnew >= {1'b0, sh_q};
		// split of a pixel that straddles a column or row boundary
		wh_nx = (hnew > {1'b0, sw_q}) ? DIM_W'(hnew - {1'b0, sw_q}) : '0;
		wv_nx = (vnew > {1'b0, sh_q}) ? DIM_W'(vnew - {1'b0, sh_q}) : '0;
		wh_cu = dw_q - wh_nx;
		wv_cu = dh_q - wv_nx;
		last_c = (32'(dcol_q) + 32'd1 >= 32'(dw_q)) && (32'(drow_q) + 32'd1 >= 32'(dh_q));

		par_c   = dcol_q[0];
		half_c  = AW'(dcol_q >> 1);
		adr_o_c = half_c;
		adr_e_c = par_c ? AW'(32'(half_c) + 32'd1) : half_c;
		cn_ok_c = 32'(dcol_q) + 32'd1 < 32'(MAX_DST_WIDTH);

		hph_n  = col_done ? DIM_W'(hnew - {1'b0, sw_q}) : DIM_W'(hnew);
		dcol_n = col_done ? COL_W'(32'(dcol_q) + 32'd1) : dcol_q;
		scol_n = DIM_W'(32'(scol_q) + 32'd1);
		srow_n = srow_q;
		vph_n  = vph_q;
		drow_n = drow_q;
		// end of a source row
		if (32'(scol_q) + 32'd1 >= 32'(sw_q)) begin
			scol_n = '0;
			hph_n  = '0;
			dcol_n = '0;
			if (row_done) begin
				vph_n  = DIM_W'(vnew - {1'b0, sh_q});
				drow_n = DIM_W'(32'(drow_q) + 32'd1);
			end else begin
				vph_n = DIM_W'(vnew);
			end
			srow_n = DIM_W'(32'(srow_q) + 32'd1);
			// end of the frame
			if (32'(srow_q) + 32'd1 >= 32'(sh_q)) begin
				srow_n = '0;
				vph_n  = '0;
				drow_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			scol_q  <= '0;
			srow_q  <= '0;
			hph_q   <= '0;
			vph_q   <= '0;
			dcol_q  <= '0;
			drow_q  <= '0;
		end else begin
			state_q <= state_n;
			if (wr_en) begin
				clr_q  <= '0;
				scol_q <= '0;
				srow_q <= '0;
				hph_q  <= '0;
				vph_q  <= '0;
				dcol_q <= '0;
				drow_q <= '0;
			end else begin
				if (clr_we) clr_q <= clr_q + AW'(1);
				if (accept) begin
					scol_q <= scol_n;
					srow_q <= srow_n;
					hph_q  <= hph_n;
					vph_q  <= vph_n;
					dcol_q <= dcol_n;
					drow_q <= drow_n;
				end
			end
		end
	end

	// item held for the duration of its work
	logic [PIX_W-1:0] pix_q [CHANNELS];
	logic [DIM_W-1:0] wh_cu_q, wh_nx_q, wv_cu_q, wv_nx_q;
	logic             last_q, par_q, cn_ok_q, cb_q;
	logic [POS_W-1:0] col_q, row_q;
	logic [AW-1:0]    adr_e_q, adr_o_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (ch == 0) pix_q[ch] <= pix.red_in;
				else if (ch == 1) pix_q[ch] <= pix.green_in;
				else if (ch == 2) pix_q[ch] <= pix.blue_in;
				else pix_q[ch] <= '0;
			end
			wh_cu_q <= wh_cu;
			wh_nx_q <= wh_nx;
			wv_cu_q <= wv_cu;
			wv_nx_q <= wv_nx;
			emit_q  <= row_done & col_done;
			last_q  <= last_c;
			par_q   <= par_c;
			cn_ok_q <= cn_ok_c;
			cb_q    <= drow_q[0];
			col_q   <= POS_W'(dcol_q);
			row_q   <= POS_W'(drow_q);
			adr_e_q <= adr_e_c;
			adr_o_q <= adr_o_c;
		end
	end

	// weight products: cur/cur, next-row/cur, cur/next-col, next/next
	logic [WP_W-1:0]  wp_s1 [4];
	logic [ACC_W-1:0] cp_s2 [4][CHANNELS];

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1) begin
			wp_s1[0] <= wv_cu_q * wh_cu_q;
			wp_s1[1] <= wv_nx_q * wh_cu_q;
			wp_s1[2] <= wv_cu_q * wh_nx_q;
			wp_s1[3] <= wv_nx_q * wh_nx_q;
		end
		if (state_q == ST_MUL2) begin
			for (int k = 0; k < 4; k++) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					cp_s2[k][ch] <= ACC_W'(pix_q[ch] * wp_s1[k]);
				end
			end
		end
	end

	// accumulator rams, even and odd output columns
	logic [ENT_W-1:0] mem_e [HALF];
	logic [ENT_W-1:0] mem_o [HALF];
	logic [ENT_W-1:0] rd_e_q, rd_o_q;
	logic [ENT_W-1:0] old_c, old_n, new_c, new_n, wd_e, wd_o;
	logic [AW-1:0]    wa_e, wa_o;
	logic             we_e, we_o;
	logic [ACC_W-1:0] sum_c [CHANNELS];

	always_comb begin
		old_c = par_q ? rd_o_q : rd_e_q;
		old_n = par_q ? rd_e_q : rd_o_q;
		new_c = old_c;
		new_n = old_n;
		for (int b = 0; b < 2; b++) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (1'(b) == cb_q) begin
					new_c[(b*CHANNELS+ch)*ACC_W +: ACC_W] =
						emit_q ? '0 : old_c[(b*CHANNELS+ch)*ACC_W +: ACC_W] + cp_s2[0][ch];
					new_n[(b*CHANNELS+ch)*ACC_W +: ACC_W] =
						old_n[(b*CHANNELS+ch)*ACC_W +: ACC_W] + cp_s2[2][ch];
				end else begin
					new_c[(b*CHANNELS+ch)*ACC_W +: ACC_W] =
						old_c[(b*CHANNELS+ch)*ACC_W +: ACC_W] + cp_s2[1][ch];
					new_n[(b*CHANNELS+ch)*ACC_W +: ACC_W] =
						old_n[(b*CHANNELS+ch)*ACC_W +: ACC_W] + cp_s2[3][ch];
				end
			end
		end
		// finished sum of the pixel being emitted
		for (int ch = 0; ch < CHANNELS; ch++) begin
			sum_c[ch] = (cb_q ? old_c[(CHANNELS+ch)*ACC_W +: ACC_W]
				: old_c[ch*ACC_W +: ACC_W]) + cp_s2[0][ch];
		end

		we_e = clr_we | (wb_we & (!par_q | cn_ok_q));
		we_o = clr_we | (wb_we & (par_q | cn_ok_q));
		wa_e = clr_we ? clr_q : adr_e_q;
		wa_o = clr_we ? clr_q : adr_o_q;
		wd_e = clr_we ? '0 : (par_q ? new_n : new_c);
		wd_o = clr_we ? '0 : (par_q ? new_c : new_n);
	end

	always_ff @(posedge clk) begin
		if (we_e) mem_e[wa_e] <= wd_e;
		if (rd_en) rd_e_q <= mem_e[adr_e_c];
	end

	always_ff @(posedge clk) begin
		if (we_o) mem_o[wa_o] <= wd_o;
		if (rd_en) rd_o_q <= mem_o[adr_o_c];
	end

	// round-half-up average
	logic [PIX_W-1:0] quo [CHANNELS];

	aard_round_div #(
		.CHANNELS (CHANNELS),
		.ACC_W    (ACC_W),
		.D_W      (WP_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (sum_c),
		.d      (d_q),
		.done   (div_done),
		.quo    (quo)
	);

	// output register, frees the input side while a result waits
	logic             res_v_q, last_out_q;
	logic [PIX_W-1:0] color_q [3];
	logic [PIX_W-1:0] color_c [3];
	logic [POS_W-1:0] col_out_q, row_out_q;

	always_comb begin
		for (int i = 0; i < 3; i++) color_c[i] = '0;
		for (int i = 0; i < CHANNELS && i < 3; i++) color_c[i] = quo[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (load_out) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			color_q    <= color_c;
			col_out_q  <= col_q;
			row_out_q  <= row_q;
			last_out_q <= last_q;
		end
	end

	assign res.valid      = res_v_q;
	assign res.red_out    = color_q[0];
	assign res.green_out  = color_q[1];
	assign res.blue_out   = color_q[2];
	assign res.out_col    = col_out_q;
	assign res.out_row    = row_out_q;
	assign res.frame_last = last_out_q;
endmodule

/* hw/rtl/aard_checker.sv */
`include "area_average_rgb_downscaler_defines.svh"

module aard_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        wr_en,
	input logic [48:0] res_payload
);
	// a waiting result holds still
	`AARD_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_payload), "result changed while stalled")
	// one item in flight at a time
	`AARD_ASSERT_NEXT(a_one_item, clk, arst_n, pix_valid && pix_ready, !pix_ready, "item accepted while busy")
	// a register write starts the clearing sweep
	`AARD_ASSERT_NEXT(a_cfg_sweep, clk, arst_n, wr_en, !pix_ready, "ready right after a register write")
	// no item taken during a burst of back-to-back register writes
	`AARD_ASSERT_SAME(a_cfg_quiet, clk, arst_n, wr_en && $past(wr_en), !pix_ready, "ready during write burst")
endmodule

bind area_average_rgb_downscaler aard_checker u_aard_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_valid   (pix.valid),
	.pix_ready   (pix.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.wr_en       (wr_en),
	.res_payload ({res.red_out, res.green_out, res.blue_out, res.out_col, res.out_row,
		res.frame_last})
);
